// ----- rtl/square_wave_tone_generator_top_defines.svh -----
// assertion macros for the tone generator
`ifndef SQUARE_WAVE_TONE_GENERATOR_TOP_DEFINES_SVH
`define SQUARE_WAVE_TONE_GENERATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SQW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SQW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SQW_ASSERT(lbl, prop, msg)
`define SQW_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/sqw_pkg.sv -----
`default_nettype none
package sqw_pkg;

    localparam int RATE_W   = 20;
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 8;
    localparam int HP_W     = 17;
    localparam int TOG_W    = 23;
    localparam int RATE_RST = 250000;
    localparam int HALF_MAX = 65536;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_CALC
    } sqw_state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } sqw_stat_t;

endpackage
`default_nettype wire

// ----- rtl/sqw_div.sv -----
`default_nettype none
module sqw_div #(
    parameter int NUM_W = sqw_pkg::RATE_W,
    parameter int DEN_W = sqw_pkg::FREQ_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output sqw_pkg::sqw_stat_t    stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- rtl/sqw_mul.sv -----
`default_nettype none
module sqw_mul #(
    parameter int A_W = sqw_pkg::FREQ_W,
    parameter int B_W = sqw_pkg::DUR_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] prod,
    output sqw_pkg::sqw_stat_t      stat
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [A_W:0]     sum;

    // shift-add, multiplier bit lsb first
    always_comb
    begin
        sum       = {1'b0, acc_reg[P_W-1:B_W]} + {1'b0, (b_reg[0] ? a_reg : '0)};
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = CNT_W'(B_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {sum, acc_reg[B_W-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- rtl/square_wave_tone_generator_top.sv -----
// tick item: result registered when accepted; 1 item per cycle while out_ready is high
// start item that passes the busy and zero-frequency checks: result registered when the
//   20-step bit-serial divider is done (the 8-step serial multiplier runs alongside it)
// other start items are rejected; a new item is taken once the output register is free
// asynchronous active-low reset: idle, buzzer register low, counters zero, rate 250000
`default_nettype none
`include "square_wave_tone_generator_top_defines.svh"
module square_wave_tone_generator_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sqw_pkg::RATE_W-1:0]   cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         mode,
    input  wire logic [sqw_pkg::FREQ_W-1:0]   frequency,
    input  wire logic [sqw_pkg::DUR_W-1:0]    duration,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              buzzer_out,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              rejected
);

    localparam int RATE_W = sqw_pkg::RATE_W;
    localparam int FREQ_W = sqw_pkg::FREQ_W;
    localparam int DUR_W  = sqw_pkg::DUR_W;
    localparam int HP_W   = sqw_pkg::HP_W;
    localparam int TOG_W  = sqw_pkg::TOG_W;

    sqw_pkg::sqw_state_t state_reg, state_next;

    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [HP_W-1:0]   half_period_reg, half_period_next;
    logic [HP_W-1:0]   ticks_left_reg, ticks_left_next;
    logic [TOG_W-1:0]  toggles_left_reg, toggles_left_next;
    logic              running_reg, running_next;
    logic              buzzer_reg, buzzer_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_buzzer_reg, out_buzzer_next;
    logic              out_busy_reg, out_busy_next;
    logic              out_done_reg, out_done_next;
    logic              out_rej_reg, out_rej_next;

    logic              in_fire;
    logic              unit_start;
    logic              q_bad;
    logic              in_calc;
    logic              div_ctx_ok;
    logic              period_ok;

    logic [RATE_W-1:0]       quo;
    logic [FREQ_W+DUR_W-1:0] prod;
    sqw_pkg::sqw_stat_t      div_stat;
    sqw_pkg::sqw_stat_t      mul_stat;

    sqw_div #(
        .NUM_W (RATE_W),
        .DEN_W (FREQ_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .num   (rate_reg),
        .den   (frequency),
        .quo   (quo),
        .stat  (div_stat)
    );

    sqw_mul #(
        .A_W (FREQ_W),
        .B_W (DUR_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .a     (frequency),
        .b     (duration),
        .prod  (prod),
        .stat  (mul_stat)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == sqw_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;

    assign q_bad = (quo == '0) || (quo > RATE_W'(sqw_pkg::HALF_MAX));

    assign in_calc    = (state_reg == sqw_pkg::ST_CALC);
    assign div_ctx_ok = in_calc && !out_valid_reg && !mul_stat.busy;
    assign period_ok  = (half_period_reg != '0) && (ticks_left_reg != '0);

    always_comb
    begin
        state_next        = state_reg;
        rate_next         = rate_reg;
        half_period_next  = half_period_reg;
        ticks_left_next   = ticks_left_reg;
        toggles_left_next = toggles_left_reg;
        running_next      = running_reg;
        buzzer_next       = buzzer_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_buzzer_next   = out_buzzer_reg;
        out_busy_next     = out_busy_reg;
        out_done_next     = out_done_reg;
        out_rej_next      = out_rej_reg;
        unit_start        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            rate_next = cfg_data;
        end

        unique case (state_reg)
            sqw_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == sqw_pkg::MODE_START)
                    begin
                        if (running_reg || (frequency == '0))
                        begin
                            out_valid_next  = 1'b1;
                            out_buzzer_next = buzzer_reg;
                            out_busy_next   = running_reg;
                            out_done_next   = 1'b0;
                            out_rej_next    = 1'b1;
                        end
                        else
                        begin
                            unit_start = 1'b1;
                            state_next = sqw_pkg::ST_CALC;
                        end
                    end
                    else
                    begin
                        out_done_next = 1'b0;
                        if (running_reg)
                        begin
                            if (ticks_left_reg <= HP_W'(1))
                            begin
                                ticks_left_next = half_period_reg;
                                if (toggles_left_reg != '0)
                                begin
                                    toggles_left_next = toggles_left_reg - 1'b1;
                                    buzzer_next       = !buzzer_reg;
                                end
                                else
                                begin
                                    buzzer_next   = 1'b0;
                                    running_next  = 1'b0;
                                    out_done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                ticks_left_next = ticks_left_reg - 1'b1;
                            end
                        end
                        out_valid_next  = 1'b1;
                        out_buzzer_next = buzzer_next;
                        out_busy_next   = running_next;
                        out_rej_next    = 1'b0;
                    end
                end
            end
            sqw_pkg::ST_CALC:
            begin
                if (div_stat.done)
                begin
                    if (!q_bad)
                    begin
                        half_period_next  = quo[HP_W-1:0];
                        ticks_left_next   = quo[HP_W-1:0];
                        toggles_left_next = prod[TOG_W:1];
                        running_next      = 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_buzzer_next = buzzer_reg;
                    out_busy_next   = !q_bad;
                    out_done_next   = 1'b0;
                    out_rej_next    = q_bad;
                    state_next      = sqw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sqw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sqw_pkg::ST_IDLE;
            rate_reg         <= RATE_W'(sqw_pkg::RATE_RST);
            half_period_reg  <= '0;
            ticks_left_reg   <= '0;
            toggles_left_reg <= '0;
            running_reg      <= 1'b0;
            buzzer_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rate_reg         <= rate_next;
            half_period_reg  <= half_period_next;
            ticks_left_reg   <= ticks_left_next;
            toggles_left_reg <= toggles_left_next;
            running_reg      <= running_next;
            buzzer_reg       <= buzzer_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_buzzer_reg <= out_buzzer_next;
        out_busy_reg   <= out_busy_next;
        out_done_reg   <= out_done_next;
        out_rej_reg    <= out_rej_next;
    end

    assign out_valid  = out_valid_reg;
    assign buzzer_out = out_buzzer_reg;
    assign busy_res   = out_busy_reg;
    assign done_res   = out_done_reg;
    assign rejected   = out_rej_reg;

    // quotient ready only in calc, with an empty output slot and the product finished
    `SQW_ASSERT(a_div_done_ctx, div_stat.done |-> div_ctx_ok, "divider finished out of context")
    `SQW_ASSERT(a_calc_blocks_in, in_calc |-> !in_ready, "input taken during calc")
    `SQW_ASSERT(a_run_period, running_reg |-> period_ok, "running with zero period")
    `SQW_NEVER(a_done_rej, out_valid_reg && out_done_reg && out_rej_reg, "done and reject")
    `SQW_NEVER(a_done_busy, out_valid_reg && out_done_reg && out_busy_reg, "done while still busy")

endmodule
`default_nettype wire
